>>> design/npmg_pkg.sv
// Shared types and constants for the near pair midpoint generator.
`default_nettype none

package npmg_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_W        = 16;
   localparam int RADIUS_W       = 15;
   localparam int R2_W           = 2 * RADIUS_W;
   localparam int SQ_W           = 2 * COORD_W;
   localparam int RSP_IDX_W      = 6;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd82;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] vx;
      logic [COORD_W-1:0] vy;
      logic [COORD_W-1:0] mag;
   } pt_type;

   typedef struct packed {
      logic [COORD_W-1:0] mx;
      logic [COORD_W-1:0] my;
      logic [COORD_W-1:0] mvx;
      logic [COORD_W-1:0] mvy;
      logic [COORD_W-1:0] mmag;
   } res_type;

   // floor of the half sum of two signed 16-bit values
   function automatic logic [COORD_W-1:0] half_sum_s(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
      logic [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      return s[COORD_W:1];
   endfunction

   // floor of the half sum of two unsigned 16-bit values
   function automatic logic [COORD_W-1:0] half_sum_u(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
      logic [COORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_W:1];
   endfunction

   // magnitude of the signed difference a - b
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] n;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      n = -d;
      return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> design/near_pair_midpoint_generator.sv
// Top level of the near pair midpoint generator.
// Use: write the proximity radius on the csr_ channel while the block is idle
// (reset value 82). Each req_ transfer either clears the point store
// (opcode clear) or adds a point (opcode add). An add rotates the whole chain
// of MAX_POINTS cells once, testing each stored point against the new one
// and writing the new point into the first free cell on the way. Every near
// pair gives one rsp_ transfer; rsp_last marks the final one of an add.
// An add to a full store gives a single transfer with rsp_store_full set.
// Sequence: an add is accepted, the chain rotates one cell per cycle unless
// a result stall holds it, the distance pipeline drains and the held result
// is handed over, and only then is the next req_ transfer taken. A clear
// leaves the block idle and ready for the next req_ transfer; a full-store
// add waits in its own state until the output register is free.
// A result sits in the output register while the next req_ transfer is taken.
// If the receiver stalls, the rotation holds once a second result is ready,
// so no result is lost. Reset empties the store and sets the radius to 82;
// the stored points themselves are not cleared.
`default_nettype none

module near_pair_midpoint_generator
   import npmg_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [RADIUS_W-1:0]  csr_radius,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_opcode,
   input  wire logic [COORD_W-1:0]   req_pos_x,
   input  wire logic [COORD_W-1:0]   req_pos_y,
   input  wire logic [COORD_W-1:0]   req_vel_x,
   input  wire logic [COORD_W-1:0]   req_vel_y,
   input  wire logic [COORD_W-1:0]   req_magnitude_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [RSP_IDX_W-1:0]      rsp_first_index,
   output logic [RSP_IDX_W-1:0]      rsp_second_index,
   output logic [COORD_W-1:0]        rsp_mid_x,
   output logic [COORD_W-1:0]        rsp_mid_y,
   output logic [COORD_W-1:0]        rsp_mid_vx,
   output logic [COORD_W-1:0]        rsp_mid_vy,
   output logic [COORD_W-1:0]        rsp_mid_magnitude,
   output logic                      rsp_store_full,
   output logic                      rsp_last
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int STEP_W = $clog2(MAX_POINTS + 3);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_POINTS);
   localparam logic [STEP_W-1:0] STEP_ROT  = STEP_W'(MAX_POINTS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_POINTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_FULL
   } state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [STEP_W-1:0]     step_ff;
   pt_type                np_ff;
   logic [RADIUS_W-1:0]   radius_ff;
   logic [R2_W-1:0]       r2_ff;

   logic                  pend_valid_ff;
   logic [IDX_W-1:0]      pend_idx_ff;
   res_type               pend_ff;

   logic                  rsp_valid_ff;
   logic [RSP_IDX_W-1:0]  rsp_first_ff;
   logic [RSP_IDX_W-1:0]  rsp_second_ff;
   res_type               rsp_res_ff;
   logic                  rsp_full_ff;
   logic                  rsp_last_ff;

   pt_type                cell_q [MAX_POINTS];
   logic                  out_free;
   logic                  adv;
   logic                  rotating;
   logic                  shift;
   logic                  scan_valid;
   logic                  hit;
   logic [IDX_W-1:0]      hit_idx;
   res_type               hit_res;
   logic                  req_xfer;
   logic                  rsp_load;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign adv       = !(hit && pend_valid_ff && !out_free);
   assign rotating  = (state_ff == ST_SCAN) && (step_ff < STEP_ROT);
   assign shift     = rotating && adv;
   assign scan_valid = rotating && (step_ff < STEP_W'(count_ff));
   assign rsp_load  = ((state_ff == ST_SCAN) && adv && hit && pend_valid_ff) ||
                      ((state_ff == ST_FLUSH) && pend_valid_ff && out_free) ||
                      ((state_ff == ST_FULL) && out_free);

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      if (i == MAX_POINTS - 1) begin : g_tail
         npmg_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .load_new (step_ff == STEP_W'(count_ff)),
            .neighbor (cell_q[0]),
            .new_pt   (np_ff),
            .point    (cell_q[i])
         );
      end else begin : g_body
         npmg_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .load_new (1'b0),
            .neighbor (cell_q[i+1]),
            .new_pt   (np_ff),
            .point    (cell_q[i])
         );
      end
   end

   npmg_cmp #(
      .IDX_W (IDX_W)
   ) u_cmp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (scan_valid),
      .in_idx    (step_ff[IDX_W-1:0]),
      .stored_pt (cell_q[0]),
      .new_pt    (np_ff),
      .r2        (r2_ff),
      .hit       (hit),
      .hit_idx   (hit_idx),
      .hit_res   (hit_res)
   );

   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_radius;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (req_opcode == OP_CLEAR) begin
                     count_ff <= '0;
                  end else if (count_ff == CNT_FULL) begin
                     state_ff <= ST_FULL;
                  end else begin
                     np_ff.x   <= req_pos_x;
                     np_ff.y   <= req_pos_y;
                     np_ff.vx  <= req_vel_x;
                     np_ff.vy  <= req_vel_y;
                     np_ff.mag <= req_magnitude_in;
                     step_ff   <= '0;
                     state_ff  <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (adv) begin
                  if (hit) begin
                     if (pend_valid_ff) begin
                        rsp_first_ff  <= RSP_IDX_W'(pend_idx_ff);
                        rsp_second_ff <= RSP_IDX_W'(count_ff);
                        rsp_res_ff    <= pend_ff;
                        rsp_full_ff   <= 1'b0;
                        rsp_last_ff   <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_idx_ff   <= hit_idx;
                     pend_ff       <= hit_res;
                  end
                  if (step_ff == STEP_LAST) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     step_ff <= step_ff + 1'b1;
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_valid_ff) begin
                  count_ff <= count_ff + 1'b1;
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_first_ff  <= RSP_IDX_W'(pend_idx_ff);
                  rsp_second_ff <= RSP_IDX_W'(count_ff);
                  rsp_res_ff    <= pend_ff;
                  rsp_full_ff   <= 1'b0;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  count_ff      <= count_ff + 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_FULL: begin
               if (out_free) begin
                  rsp_first_ff  <= '0;
                  rsp_second_ff <= RSP_IDX_W'(MAX_POINTS);
                  rsp_res_ff    <= '0;
                  rsp_full_ff   <= 1'b1;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_first_index   = rsp_first_ff;
   assign rsp_second_index  = rsp_second_ff;
   assign rsp_mid_x         = rsp_res_ff.mx;
   assign rsp_mid_y         = rsp_res_ff.my;
   assign rsp_mid_vx        = rsp_res_ff.mvx;
   assign rsp_mid_vy        = rsp_res_ff.mvy;
   assign rsp_mid_magnitude = rsp_res_ff.mmag;
   assign rsp_store_full    = rsp_full_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

>>> design/npmg_cell.sv
// One storage cell of the rotating point chain.
`default_nettype none

module npmg_cell
   import npmg_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   shift,
   input  wire logic   load_new,
   input  wire pt_type neighbor,
   input  wire pt_type new_pt,
   output pt_type      point
);

   pt_type point_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         point_ff <= load_new ? new_pt : neighbor;
      end
   end

   assign point = point_ff;

endmodule

`default_nettype wire

>>> design/npmg_cmp.sv
// Distance test and midpoint pipeline for the point leaving the chain head.
`default_nettype none

module npmg_cmp
   import npmg_pkg::*;
#(
   parameter int IDX_W = 6
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire logic [IDX_W-1:0] in_idx,
   input  wire pt_type           stored_pt,
   input  wire pt_type           new_pt,
   input  wire logic [R2_W-1:0]  r2,
   output logic                  hit,
   output logic [IDX_W-1:0]      hit_idx,
   output res_type               hit_res
);

   logic               s1_valid_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   logic [COORD_W-1:0] s1_ax_ff;
   logic [COORD_W-1:0] s1_ay_ff;
   res_type            s1_res_ff;
   res_type            s1_res_in;

   logic               s2_valid_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic [SQ_W-1:0]    s2_sqx_ff;
   logic [SQ_W-1:0]    s2_sqy_ff;
   res_type            s2_res_ff;

   logic [SQ_W:0]      dist2;

   always_comb begin
      s1_res_in.mx   = half_sum_s(stored_pt.x, new_pt.x);
      s1_res_in.my   = half_sum_s(stored_pt.y, new_pt.y);
      s1_res_in.mvx  = half_sum_s(stored_pt.vx, new_pt.vx);
      s1_res_in.mvy  = half_sum_s(stored_pt.vy, new_pt.vy);
      s1_res_in.mmag = half_sum_u(stored_pt.mag, new_pt.mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff <= in_idx;
         s1_ax_ff  <= abs_diff(new_pt.x, stored_pt.x);
         s1_ay_ff  <= abs_diff(new_pt.y, stored_pt.y);
         s1_res_ff <= s1_res_in;
         s2_idx_ff <= s1_idx_ff;
         s2_sqx_ff <= s1_ax_ff * s1_ax_ff;
         s2_sqy_ff <= s1_ay_ff * s1_ay_ff;
         s2_res_ff <= s1_res_ff;
      end
   end

   assign dist2   = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};
   assign hit     = s2_valid_ff && (dist2 < (SQ_W + 1)'(r2));
   assign hit_idx = s2_idx_ff;
   assign hit_res = s2_res_ff;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for the near pair midpoint generator: directed table, then clustered random traffic.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import npmg_pkg::*;

   localparam int NPTS          = MAX_POINTS_DEF;
   localparam int SETTLE_CYCLES = NPTS + 16;
   localparam int LONG_HOLD     = 400;

   typedef struct packed {
      logic                      opcode;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] vx;
      logic signed [COORD_W-1:0] vy;
      logic [COORD_W-1:0]        mag;
   } sample_type;

   typedef struct packed {
      logic [RSP_IDX_W-1:0] first_idx;
      logic [RSP_IDX_W-1:0] second_idx;
      logic [COORD_W-1:0]   mx;
      logic [COORD_W-1:0]   my;
      logic [COORD_W-1:0]   mvx;
      logic [COORD_W-1:0]   mvy;
      logic [COORD_W-1:0]   mmag;
      logic                 full;
      logic                 last;
   } midpoint_type;

   typedef midpoint_type mid_q_type[$];

   typedef struct {
      sample_type   s;
      bit           typed;
      midpoint_type m;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [RADIUS_W-1:0]  csr_radius;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_opcode;
   logic [COORD_W-1:0]   req_pos_x;
   logic [COORD_W-1:0]   req_pos_y;
   logic [COORD_W-1:0]   req_vel_x;
   logic [COORD_W-1:0]   req_vel_y;
   logic [COORD_W-1:0]   req_magnitude_in;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [RSP_IDX_W-1:0] rsp_first_index;
   logic [RSP_IDX_W-1:0] rsp_second_index;
   logic [COORD_W-1:0]   rsp_mid_x;
   logic [COORD_W-1:0]   rsp_mid_y;
   logic [COORD_W-1:0]   rsp_mid_vx;
   logic [COORD_W-1:0]   rsp_mid_vy;
   logic [COORD_W-1:0]   rsp_mid_magnitude;
   logic                 rsp_store_full;
   logic                 rsp_last;

   sample_type          stored_pts[NPTS];
   int unsigned         stored_count;
   logic [RADIUS_W-1:0] radius_now;
   midpoint_type        expected_mids[$];
   row_type             directed[$];
   int                  errors, n_req, n_clear, n_results, n_full, n_radius;
   bit                  hold_armed, calm;

   near_pair_midpoint_generator dut (.*);

   always #5 clock = ~clock;

   function automatic logic [COORD_W-1:0] floor_mean(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
      int total;
      total = int'(a) + int'(b);
      return COORD_W'(total >>> 1);
   endfunction

   function automatic mid_q_type predict_midpoints(input sample_type s);
      mid_q_type    found;
      midpoint_type m;
      sample_type   p;
      longint       dx, dy, r2;
      if (s.opcode == OP_CLEAR) begin
         stored_count = 0;
         return found;
      end
      if (stored_count >= NPTS) begin
         m = '0;
         m.second_idx = RSP_IDX_W'(NPTS);
         m.full = 1'b1;
         m.last = 1'b1;
         found.push_back(m);
         return found;
      end
      r2 = longint'(radius_now) * longint'(radius_now);
      for (int i = 0; i < int'(stored_count); i++) begin
         p = stored_pts[i];
         dx = longint'(s.x) - longint'(p.x);
         dy = longint'(s.y) - longint'(p.y);
         if (dx * dx + dy * dy < r2) begin
            m.first_idx  = RSP_IDX_W'(i);
            m.second_idx = RSP_IDX_W'(stored_count);
            m.mx   = floor_mean(p.x, s.x);
            m.my   = floor_mean(p.y, s.y);
            m.mvx  = floor_mean(p.vx, s.vx);
            m.mvy  = floor_mean(p.vy, s.vy);
            m.mmag = COORD_W'((int'(p.mag) + int'(s.mag)) >> 1);
            m.full = 1'b0;
            m.last = 1'b0;
            found.push_back(m);
         end
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      stored_pts[stored_count] = s;
      stored_count++;
      return found;
   endfunction

   function automatic string mid_text(input midpoint_type m);
      return $sformatf("idx %0d/%0d pos (%0d,%0d) vel (%0d,%0d) mag %0d full %0b last %0b",
                       m.first_idx, m.second_idx, $signed(m.mx), $signed(m.my),
                       $signed(m.mvx), $signed(m.mvy), m.mmag, m.full, m.last);
   endfunction

   task automatic add_row(input logic op, input int x, input int y, input int vx,
                          input int vy, input int mag, input bit typed = 1'b0,
                          input int fi = 0, input int si = 0, input int mx = 0,
                          input int my = 0, input int mvx = 0, input int mvy = 0,
                          input int mm = 0);
      row_type r;
      r.s = {op, COORD_W'(x), COORD_W'(y), COORD_W'(vx), COORD_W'(vy), COORD_W'(mag)};
      r.typed = typed;
      r.m = {RSP_IDX_W'(fi), RSP_IDX_W'(si), COORD_W'(mx), COORD_W'(my), COORD_W'(mvx),
             COORD_W'(mvy), COORD_W'(mm), 1'b0, 1'b1};
      directed.push_back(r);
   endtask

   task automatic offer(input sample_type s, input bit typed, input midpoint_type typed_mid);
      mid_q_type found;
      if (!calm) begin
         while ($urandom_range(99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_opcode       <= s.opcode;
      req_pos_x        <= s.x;
      req_pos_y        <= s.y;
      req_vel_x        <= s.vx;
      req_vel_y        <= s.vy;
      req_magnitude_in <= s.mag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      found = predict_midpoints(s);
      if (typed) expected_mids.push_back(typed_mid);
      else foreach (found[k]) expected_mids.push_back(found[k]);
      n_req++;
      if (s.opcode == OP_CLEAR) n_clear++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_mids.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] rad);
      csr_valid  <= 1'b1;
      csr_radius <= rad;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      radius_now = rad;
      n_radius++;
   endtask

   task automatic run_phase(input logic [RADIUS_W-1:0] rad, input int items, input int spread,
                            input int clear_pct, input int far_pct, input bit squeeze,
                            input bit steady);
      sample_type         s;
      logic [COORD_W-1:0] cx, cy;
      calm = steady;
      settle();
      write_radius(rad);
      hold_armed = squeeze;
      cx = COORD_W'($urandom);
      cy = COORD_W'($urandom);
      for (int n = 0; n < items; n++) begin
         s.opcode = (n == 0 || $urandom_range(99) < clear_pct) ? OP_CLEAR : OP_ADD;
         if (s.opcode == OP_CLEAR) begin
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
         end
         if ($urandom_range(99) < far_pct) begin
            s.x = COORD_W'($urandom);
            s.y = COORD_W'($urandom);
         end else begin
            s.x = cx + COORD_W'(int'($urandom_range(2 * spread)) - spread);
            s.y = cy + COORD_W'(int'($urandom_range(2 * spread)) - spread);
         end
         s.vx  = COORD_W'($urandom);
         s.vy  = COORD_W'($urandom);
         s.mag = COORD_W'($urandom);
         offer(s, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      reset            <= 1'b1;
      csr_valid        <= 1'b0;
      csr_radius       <= '0;
      req_valid        <= 1'b0;
      req_opcode       <= OP_CLEAR;
      req_pos_x        <= '0;
      req_pos_y        <= '0;
      req_vel_x        <= '0;
      req_vel_y        <= '0;
      req_magnitude_in <= '0;
      radius_now   = RADIUS_RESET;
      stored_count = 0;

      add_row(OP_CLEAR, 0, 0, 0, 0, 0);
      add_row(OP_ADD, 0, 0, 0, 0, 0);
      add_row(OP_ADD, 81, 0, 100, -100, 200, 1, 0, 1, 40, 0, 50, -50, 100);
      add_row(OP_ADD, 0, 82, 7, 7, 9);
      add_row(OP_ADD, -32768, -32768, -32768, -32768, 0);
      add_row(OP_ADD, -32768, -32768, 32767, 32767, 65535,
              1, 3, 4, -32768, -32768, -1, -1, 32767);
      add_row(OP_ADD, 32767, 32767, 32767, 32767, 65535);
      add_row(OP_ADD, 32767, 32767, 32767, 32767, 65535,
              1, 5, 6, 32767, 32767, 32767, 32767, 65535);
      add_row(OP_ADD, -1, -1, -1, -1, 1);
      add_row(OP_ADD, 40, 20, 5, -5, 3);
      add_row(OP_ADD, 0, -81, -300, 300, 4096);
      add_row(OP_CLEAR, 1234, -1234, 0, 0, 0);
      add_row(OP_ADD, 100, 100, -7, 9, 65535);
      add_row(OP_ADD, 100, 100, 7, -9, 65534);
      add_row(OP_ADD, 100, 181, 1, 1, 1);
      add_row(OP_CLEAR, 0, 0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) offer(directed[r].s, directed[r].typed, directed[r].m);

      run_phase(15'd32767, 69, 600, 0, 0, 1'b1, 1'b0);
      run_phase(15'd0, 25, 2, 5, 0, 1'b0, 1'b0);
      run_phase(RADIUS_RESET, 80, 60, 8, 10, 1'b0, 1'b0);
      run_phase(15'd1500, 80, 1500, 8, 10, 1'b0, 1'b1);
      run_phase(15'd400, 80, 300, 10, 30, 1'b0, 1'b0);
      run_phase(15'd7000, 70, 9000, 0, 20, 1'b0, 1'b0);
      settle();

      $display("Covered %0d requests (%0d clears) under %0d radius writes from 0 to 32767.",
               n_req, n_clear, n_radius);
      $display("Checked %0d midpoint results, %0d of them store-full drops.", n_results, n_full);
      if (errors == 0 && expected_mids.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin : rsp_side
      midpoint_type got, want;
      int           hold_left;
      bit           hold_used;
      rsp_ready <= 1'b0;
      hold_left = 0;
      hold_used = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_first_index, rsp_second_index, rsp_mid_x, rsp_mid_y, rsp_mid_vx,
                   rsp_mid_vy, rsp_mid_magnitude, rsp_store_full, rsp_last};
            n_results++;
            if (rsp_store_full) n_full++;
            if (expected_mids.size() == 0) begin
               errors++;
               $display("%0t ns: result with nothing expected: %s", $time, mid_text(got));
            end else begin
               want = expected_mids.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t ns: midpoint mismatch\n  expected %s\n  actual   %s",
                           $time, mid_text(want), mid_text(got));
               end
            end
         end
         // hold off once the block has a result waiting, so it backs up into the input
         if (hold_armed && !hold_used && rsp_valid) begin
            hold_used = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 6);
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> sim.f
design/npmg_pkg.sv
design/npmg_cell.sv
design/npmg_cmp.sv
design/near_pair_midpoint_generator.sv
test/tb_top.sv
